>>> rtl/divisor_sum_perfect_test_assert.svh
// assertion macros for the divisor sum block
`ifndef DIVISOR_SUM_PERFECT_TEST_ASSERT_SVH
`define DIVISOR_SUM_PERFECT_TEST_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DSPT_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divisor sum check failed");
`define DSPT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divisor sum check failed");
`else
`define DSPT_ASSERT_SAME(name, ante, cons)
`define DSPT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

>>> rtl/dspt_pkg.sv
// shared types and constants for the divisor sum block
package dspt_pkg;

    localparam int SUM_W       = 34;
    localparam int OUT_TDATA_W = 72;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/dspt_div.sv
// bit-serial restoring divider, one quotient bit per cycle while busy
module dspt_div #(
    parameter int DIVIDEND_W = 31,
    parameter int DIVISOR_W  = 17
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dspt_pkg::div_ctrl_t   ctrl,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output dspt_pkg::div_stat_t   stat,
    output logic [DIVIDEND_W-1:0] quotient,
    output logic [DIVISOR_W-1:0]  remainder
);

    localparam int CntW = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CntW'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit in, subtract when it fits
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/divisor_sum_perfect_test.sv
// divisor sum, aliquot sum and perfect number test by trial division
// each trial divisor runs one bit-serial divide; when it divides the value, the
//   candidate and then its cofactor are added (an exact root only once)
// one word is worked on at a time; the next word is taken only in the idle state
// a finished word waits in the output register while the next word is taken
// reset (rst_n, async, active low) clears the sequencer, divider and output valid
`include "divisor_sum_perfect_test_assert.svh"

module divisor_sum_perfect_test #(
    parameter int NUMBER_BITS = 31
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((NUMBER_BITS+7)/8)*8-1:0]     s_tdata,   // value, zero padding
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dspt_pkg::OUT_TDATA_W-1:0]     m_tdata    // divisor_sum, aliquot_sum,
                                                            // is_perfect, zero padding
);

    // candidate needs to reach floor(sqrt(max)) + 1
    localparam int CandW = (NUMBER_BITS + 1) / 2 + 1;
    // sigma(n) stays below 8n for these widths; wraps at 64 bits like a machine word
    localparam int AccW  = (NUMBER_BITS + 3 > 64) ? 64 : NUMBER_BITS + 3;
    localparam int SumW  = dspt_pkg::SUM_W;
    localparam int PadW  = dspt_pkg::OUT_TDATA_W - 2 * SumW - 1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_DIV      = 5'b00010,
        ST_ADD_CAND = 5'b00100,
        ST_ADD_COF  = 5'b01000,
        ST_FINISH   = 5'b10000
    } state_t;

    state_t                   state_reg, state_next;
    logic [NUMBER_BITS-1:0]   num_reg, num_next;
    logic [CandW-1:0]         cand_reg, cand_next;
    logic [AccW-1:0]          total_reg, total_next;
    logic                     m_valid_reg, m_valid_next;
    logic [SumW-1:0]          dsum_reg, dsum_next;
    logic [SumW-1:0]          asum_reg, asum_next;
    logic                     perf_reg, perf_next;

    dspt_pkg::div_ctrl_t      div_ctrl;
    dspt_pkg::div_stat_t      div_stat;
    logic [NUMBER_BITS-1:0]   div_dividend;
    logic [NUMBER_BITS-1:0]   div_q;
    logic [CandW-1:0]         div_r;

    logic [NUMBER_BITS-1:0]   cand_ext;
    logic [AccW-1:0]          addend;
    logic [AccW-1:0]          aliquot;
    logic                     out_free;
    logic                     accept;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign cand_ext = NUMBER_BITS'(cand_reg);

    // one adder serves both the candidate and its cofactor
    assign addend  = (state_reg == ST_ADD_COF) ? AccW'(div_q) : AccW'(cand_reg);
    assign aliquot = total_reg - AccW'(num_reg);

    // a new divide starts on accept and each time the candidate steps
    assign div_dividend = (state_reg == ST_IDLE) ? s_tdata[NUMBER_BITS-1:0] : num_reg;

    dspt_div #(
        .DIVIDEND_W (NUMBER_BITS),
        .DIVISOR_W  (CandW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (cand_next),
        .stat      (div_stat),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next     = state_reg;
        num_next       = num_reg;
        cand_next      = cand_reg;
        total_next     = total_reg;
        m_valid_next   = m_valid_reg;
        dsum_next      = dsum_reg;
        asum_next      = asum_reg;
        perf_next      = perf_reg;
        div_ctrl.start = 1'b0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    num_next       = s_tdata[NUMBER_BITS-1:0];
                    cand_next      = CandW'(1);
                    total_next     = '0;
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    // bound test cand <= n / cand, exact form of cand*cand <= n
                    if (cand_ext > div_q)
                    begin
                        state_next = ST_FINISH;
                    end
                    else if (div_r == '0)
                    begin
                        state_next = ST_ADD_CAND;
                    end
                    else
                    begin
                        cand_next      = cand_reg + 1'b1;
                        div_ctrl.start = 1'b1;
                    end
                end
            end
            ST_ADD_CAND:
            begin
                total_next = total_reg + addend;
                if (div_q != cand_ext)
                begin
                    state_next = ST_ADD_COF;
                end
                else
                begin
                    // exact square root counted once
                    cand_next      = cand_reg + 1'b1;
                    div_ctrl.start = 1'b1;
                    state_next     = ST_DIV;
                end
            end
            ST_ADD_COF:
            begin
                total_next     = total_reg + addend;
                cand_next      = cand_reg + 1'b1;
                div_ctrl.start = 1'b1;
                state_next     = ST_DIV;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    dsum_next    = SumW'(total_reg);
                    asum_next    = SumW'(aliquot);
                    perf_next    = (num_reg != '0) && (aliquot == AccW'(num_reg));
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        cand_reg  <= cand_next;
        total_reg <= total_next;
        dsum_reg  <= dsum_next;
        asum_reg  <= asum_next;
        perf_reg  <= perf_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PadW{1'b0}}, perf_reg, asum_reg, dsum_reg};

    // ready only while the divider is idle
    `DSPT_ASSERT_SAME(a_ready_div_idle, s_tready, !div_stat.busy)
    // a divisor is only added when the candidate is within the bound
    `DSPT_ASSERT_SAME(a_add_in_bound, state_reg == ST_ADD_CAND, cand_ext <= div_q)
    // a result appears only out of the finish step
    `DSPT_ASSERT_SAME(a_result_from_finish, $rose(m_tvalid), $past(state_reg == ST_FINISH))
    // a divide start always sets the divider to work
    `DSPT_ASSERT_NEXT(a_start_idle_div, div_ctrl.start, div_stat.busy)

endmodule

>>> sim/divisor_sum_perfect_test_tb.sv
// testbench for the divisor sum and perfect number block
module divisor_sum_perfect_test_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUMBER_BITS = 31;
    localparam int IN_W        = ((NUMBER_BITS + 7) / 8) * 8;

    // the slowest correct run is set by the largest prime, which alone takes about
    // 46341 trial divisors; the rest of the words stay small
    localparam int CYCLE_LIMIT  = 10_000_000;
    // words left in the queue when all idling stops
    localparam int QUIET_TAIL   = 15;
    // cycles to watch for stray results once nothing is owed
    localparam int SETTLE_WAIT  = 200;

    // result word layout, lowest bits first: divisor_sum, aliquot_sum, is_perfect
    typedef struct packed {
        logic                       is_perfect;
        logic [dspt_pkg::SUM_W-1:0] aliquot_sum;
        logic [dspt_pkg::SUM_W-1:0] divisor_sum;
    } sums_t;

    // one queued input word; wait_empty holds it back until every sum has come out
    typedef struct packed {
        logic            wait_empty;
        logic [IN_W-1:0] word;
    } value_item_t;

    logic                             clk;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [IN_W-1:0]                  s_tdata  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [dspt_pkg::OUT_TDATA_W-1:0] m_tdata;

    value_item_t value_queue[$];
    sums_t       sums_due[$];
    int          mismatches = 0;
    int          cycle_count = 0;
    logic        in_fire = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;
    int          idle_pct = 20;

    divisor_sum_perfect_test #(
        .NUMBER_BITS (NUMBER_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // value, zero padding
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // divisor_sum, aliquot_sum, is_perfect, zero padding
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // sigma by trial division up to the integer square root; bits above the
    // value width are dropped, and a zero value gives all-zero sums
    function automatic sums_t divisor_sums(input logic [IN_W-1:0] word);
        logic [63:0] n;
        logic [63:0] total;
        logic [63:0] aliquot;
        logic [63:0] cand;
        logic [63:0] cofactor;
        sums_t       r;
        n     = '0;
        n[NUMBER_BITS-1:0] = word[NUMBER_BITS-1:0];
        total = '0;
        // cand <= n / cand is the overflow-free form of cand * cand <= n
        for (cand = 1; n != 0 && cand <= n / cand; cand++)
        begin
            if (n % cand == 0)
            begin
                cofactor = n / cand;
                total += cand;
                // a square root is counted once
                if (cofactor != cand)
                    total += cofactor;
            end
        end
        aliquot       = total - n;
        r.divisor_sum = total[dspt_pkg::SUM_W-1:0];
        r.aliquot_sum = aliquot[dspt_pkg::SUM_W-1:0];
        r.is_perfect  = (n != 0) && (aliquot == n);
        return r;
    endfunction

    task automatic queue_value(input logic [IN_W-1:0] word, input logic wait_empty);
        value_item_t it;
        it.word       = word;
        it.wait_empty = wait_empty;
        value_queue   = {value_queue, it};
    endtask

    // input driver: words go out at the falling edge, a word stays up until taken
    always @(negedge clk)
    begin : value_feed
        logic        send;
        value_item_t nxt;
        if (rst_n && !(s_tvalid && !in_fire))
        begin
            send = 1'b0;
            nxt  = '0;
            if (in_gap > 0)
                in_gap--;
            else if (value_queue.size() != 0
                     && !(value_queue[0].wait_empty && sums_due.size() != 0))
            begin
                if (value_queue.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
                    // idle now and for a random gap counted down in in_gap
                    in_gap = $urandom_range(0, 6);
                else
                begin
                    send = 1'b1;
                    nxt  = value_queue.pop_front();
                    // now and then switch between calm, light and heavy idling
                    if ($urandom_range(0, 15) == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0:       idle_pct = 0;
                            1:       idle_pct = 15;
                            default: idle_pct = 45;
                        endcase
                    end
                end
            end
            s_tvalid <= send;
            s_tdata  <= nxt.word;
        end
    end

    // result side backpressure in short random bursts, none in the tail
    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else if (value_queue.size() > QUIET_TAIL && $urandom_range(0, 99) < idle_pct)
            begin
                out_gap = $urandom_range(0, 6);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: checks results against the oldest owed sums, then records new words
    always @(posedge clk or negedge rst_n)
    begin : sums_check
        sums_t got;
        sums_t want;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(sums_t)-1:0];
                if (sums_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word: divisor_sum %0d aliquot_sum %0d perfect %0b",
                                 got.divisor_sum, got.aliquot_sum, got.is_perfect);
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (got.divisor_sum != want.divisor_sum
                        || got.aliquot_sum != want.aliquot_sum
                        || got.is_perfect != want.is_perfect)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"wrong sums: divisor_sum %0d/%0d aliquot_sum %0d/%0d",
                                      " perfect %0b/%0b (expected/actual)"},
                                     want.divisor_sum, got.divisor_sum,
                                     want.aliquot_sum, got.aliquot_sum,
                                     want.is_perfect, got.is_perfect);
                    end
                end
            end
            // a result never leaves in the cycle its word is taken, so the
            // check above always sees older words only
            if (s_tvalid && s_tready)
                sums_due = {sums_due, divisor_sums(s_tdata)};
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("divisor_sum_perfect_test: mismatch");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [IN_W-1:0] w;
        int              band;
        // directed words
        queue_value(1, 1'b0);                       // one: only itself
        queue_value(2, 1'b0);                       // smallest prime
        queue_value(0, 1'b0);                       // zero: all-zero sums, not perfect
        queue_value(3, 1'b0);
        queue_value(4, 1'b0);                       // square, root counted once
        queue_value(6, 1'b0);                       // perfect
        queue_value(7, 1'b0);
        queue_value(9, 1'b0);                       // odd square
        queue_value(12, 1'b0);                      // abundant
        queue_value(28, 1'b0);                      // perfect
        queue_value(28 | (1 << NUMBER_BITS), 1'b0); // padding bit set, must be ignored
        queue_value(496, 1'b0);                     // perfect
        queue_value(945, 1'b0);                     // odd abundant
        queue_value(8128, 1'b1);                    // perfect, sent into an empty block
        queue_value(65536, 1'b0);                   // power of two, square
        queue_value(33550336, 1'b0);                // fifth perfect number
        queue_value((1 << NUMBER_BITS) - 1, 1'b0);  // largest value, a prime, all bits set
        queue_value(1 << (NUMBER_BITS - 8), 1'b0);  // power of two, not a square

        // random words: mostly small so the trial loop stays short
        for (int k = 0; k < 100; k++)
        begin
            band = $urandom_range(0, 99);
            if (band < 85)
                w = $urandom_range(1, 4095);
            else if (band < 95)
                w = $urandom_range(4096, 65535);
            else
                w = $urandom_range(65536, 1048575);
            // one mid-run word waits until the block has drained
            queue_value(w, k == 50);
        end

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        while (value_queue.size() != 0 || s_tvalid || sums_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("divisor_sum_perfect_test: match");
        else
            $display("divisor_sum_perfect_test: mismatch");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/dspt_pkg.sv
rtl/dspt_div.sv
rtl/divisor_sum_perfect_test.sv
sim/divisor_sum_perfect_test_tb.sv
